@@ hw/rtl/lsdrs_pkg.sv @@
package lsdrs_pkg;

  localparam int unsigned VAL_W     = 31;
  // bits of the divider retired per cycle
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned DIV_CYC   = (VAL_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DIV_W     = DIV_CYC * DIV_STEPS;
  localparam int unsigned DIV_CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CNT_RD,
    ST_CNT_START,
    ST_CNT_DIV,
    ST_PREFIX,
    ST_SC_RD,
    ST_SC_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

endpackage

@@ hw/rtl/lsdrs_if.sv @@
interface lsdrs_in_if
  import lsdrs_pkg::*;
();
  logic valid;
  logic ready;
  val_t value;
  logic last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lsdrs_out_if
  import lsdrs_pkg::*;
();
  logic valid;
  logic ready;
  val_t sorted_value;
  logic last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

@@ hw/rtl/lsdrs_div.sv @@
module lsdrs_div
  import lsdrs_pkg::*;
#(
  parameter int unsigned BASE = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  val_t                    dividend_i,
  output logic                    done_o,
  output val_t                    quot_o,
  output logic [$clog2(BASE)-1:0] rem_o
);

  localparam int unsigned RW = $clog2(BASE);
  localparam logic [RW:0] BASE_C = (RW+1)'(BASE);

  logic [DIV_W-1:0]     num_q, num_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [RW:0]          rem_q, rem_d;
  logic [DIV_CNT_W-1:0] step_q;
  logic                 busy_q;
  logic                 done_q;

  // restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_d = {rem_d[RW-1:0], num_d[DIV_W-1]};
      num_d = {num_d[DIV_W-2:0], 1'b0};
      if (rem_d >= BASE_C) begin
        rem_d = rem_d - BASE_C;
        quo_d = {quo_d[DIV_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q + DIV_CNT_W'(1);
      if (step_q == DIV_CNT_W'(DIV_CYC - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= DIV_W'(dividend_i);
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[VAL_W-1:0];
  assign rem_o  = rem_q[RW-1:0];

endmodule

@@ hw/rtl/lsdrs_mem.sv @@
module lsdrs_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lsd_radix_sorter.sv @@
// LSD radix sorter.
// in_i carries value and last; a transfer is valid && ready. Values are loaded
// one per cycle into a MAX_ITEMS-entry store; values beyond capacity are dropped.
// A transfer with last set starts the sort and drops ready until the run is out.
// The sort makes one stable bucket pass per base-DIGIT_BASE digit of the largest
// value (at least one). A pass is a count sweep, a prefix sum over the digit
// counters and a scatter sweep into the second store; the stores then swap.
// Digits come from a shared divide-by-DIGIT_BASE unit (8 bits per cycle); each
// store entry keeps its running quotient next to its value.
// Within a pass the count sweep (one store read, one division and one write back
// per value) dominates.
// Each result is read from the store and loaded into the output register.
// Sorted values leave on out_o in ascending order, last_out set on the final one.
// A stalled receiver holds the output register and the sequencer waits.
// After the final transfer the block is back in load state with ready high.
// Reset empties the set and returns to loading; the stores need no clearing.
module lsd_radix_sorter
  import lsdrs_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DIGIT_BASE = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsdrs_in_if.sink      in_i,
  lsdrs_out_if.source   out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DIG_W = $clog2(DIGIT_BASE);
  localparam int unsigned ENT_W = 2 * VAL_W + DIG_W;

  typedef struct packed {
    val_t             value;
    val_t             quo;
    logic [DIG_W-1:0] digit;
  } ent_t;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [DIG_W-1:0] dsel_q, dsel_d;
  logic [CNT_W-1:0] acc_q, acc_d;
  logic             nz_q, nz_d;
  logic             sel_q, sel_d;
  logic [CNT_W-1:0] cnt_q [DIGIT_BASE];
  logic [CNT_W-1:0] cnt_d [DIGIT_BASE];
  logic             out_valid_q, out_valid_d;
  val_t             out_val_q, out_val_d;
  logic             out_last_q, out_last_d;

  logic             in_ready;
  logic             last_idx;
  logic [DIG_W-1:0] cnt_idx;
  logic [CNT_W-1:0] cnt_rd;

  logic             rd_en;
  logic             wr_src, wr_dst;
  logic [IDX_W-1:0] src_addr, dst_addr;
  ent_t             src_data, dst_data;
  ent_t             rd_ent;
  logic             mem_we    [2];
  logic [IDX_W-1:0] mem_waddr [2];
  logic [ENT_W-1:0] mem_wdata [2];
  logic [ENT_W-1:0] mem_rdata [2];

  logic             div_start;
  logic             div_done;
  val_t             div_quo;
  logic [DIG_W-1:0] div_rem;

  assign last_idx = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;
  assign cnt_rd   = cnt_q[cnt_idx];
  assign rd_ent   = sel_q ? mem_rdata[1] : mem_rdata[0];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    dsel_d      = dsel_q;
    acc_d       = acc_q;
    nz_d        = nz_q;
    sel_d       = sel_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    wr_src      = 1'b0;
    wr_dst      = 1'b0;
    div_start   = 1'b0;
    cnt_idx     = '0;
    src_addr    = idx_q;
    src_data    = rd_ent;
    dst_addr    = cnt_rd[IDX_W-1:0];
    dst_data    = rd_ent;

    unique case (state_q)
      ST_LOAD: begin
        in_ready = 1'b1;
        src_addr = n_q[IDX_W-1:0];
        src_data = '{value: in_i.value, quo: in_i.value, digit: '0};
        if (in_i.valid) begin
          if (n_q < CNT_W'(MAX_ITEMS)) begin
            wr_src = 1'b1;
            n_d    = n_q + CNT_W'(1);
          end
          if (in_i.last) begin
            idx_d   = '0;
            nz_d    = 1'b0;
            state_d = ST_CNT_RD;
          end
        end
      end
      ST_CNT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_CNT_START;
      end
      ST_CNT_START: begin
        div_start = 1'b1;
        state_d   = ST_CNT_DIV;
      end
      ST_CNT_DIV: begin
        cnt_idx = div_rem;
        if (div_done) begin
          wr_src          = 1'b1;
          src_data        = '{value: rd_ent.value, quo: div_quo, digit: div_rem};
          cnt_d[div_rem]  = cnt_rd + CNT_W'(1);
          if (div_quo != '0) begin
            nz_d = 1'b1;
          end
          if (last_idx) begin
            acc_d   = '0;
            dsel_d  = '0;
            state_d = ST_PREFIX;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_CNT_RD;
          end
        end
      end
      ST_PREFIX: begin
        // counts become bucket start addresses
        cnt_idx       = dsel_q;
        cnt_d[dsel_q] = acc_q;
        acc_d         = CNT_W'(acc_q + cnt_rd);
        if (dsel_q == DIG_W'(DIGIT_BASE - 1)) begin
          idx_d   = '0;
          state_d = ST_SC_RD;
        end else begin
          dsel_d = dsel_q + DIG_W'(1);
        end
      end
      ST_SC_RD: begin
        rd_en   = 1'b1;
        state_d = ST_SC_WR;
      end
      ST_SC_WR: begin
        cnt_idx             = rd_ent.digit;
        wr_dst              = 1'b1;
        cnt_d[rd_ent.digit] = cnt_rd + CNT_W'(1);
        if (last_idx) begin
          sel_d = ~sel_q;
          idx_d = '0;
          if (nz_q) begin
            // some quotient still nonzero: another digit to sort on
            for (int d = 0; d < DIGIT_BASE; d++) begin
              cnt_d[d] = '0;
            end
            nz_d    = 1'b0;
            state_d = ST_CNT_RD;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_SC_RD;
        end
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_val_d   = rd_ent.value;
        out_last_d  = last_idx;
        state_d     = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            n_d = '0;
            for (int d = 0; d < DIGIT_BASE; d++) begin
              cnt_d[d] = '0;
            end
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      n_q         <= '0;
      dsel_q      <= '0;
      acc_q       <= '0;
      nz_q        <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int d = 0; d < DIGIT_BASE; d++) begin
        cnt_q[d] <= '0;
      end
    end else begin
      idx_q       <= idx_d;
      n_q         <= n_d;
      dsel_q      <= dsel_d;
      acc_q       <= acc_d;
      nz_q        <= nz_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  // ping-pong stores: sel_q names the one holding the current order
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (sel_q == k[0]) begin
        mem_we[k]    = wr_src;
        mem_waddr[k] = src_addr;
        mem_wdata[k] = src_data;
      end else begin
        mem_we[k]    = wr_dst;
        mem_waddr[k] = dst_addr;
        mem_wdata[k] = dst_data;
      end
    end
  end

  lsdrs_mem #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (ENT_W)
  ) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (mem_we[0]),
    .waddr_i (mem_waddr[0]),
    .wdata_i (mem_wdata[0]),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata[0])
  );

  lsdrs_mem #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (ENT_W)
  ) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (mem_we[1]),
    .waddr_i (mem_waddr[1]),
    .wdata_i (mem_wdata[1]),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata[1])
  );

  lsdrs_div #(
    .BASE (DIGIT_BASE)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_ent.quo),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_val_q;
  assign out_o.last_out     = out_last_q;

endmodule

@@ hw/rtl/lsdrs_checker.sv @@
module lsdrs_checker
  import lsdrs_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i,
  input val_t out_value_i
);

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  a_last_stops_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
    else $error("ready still high after the closing input transfer");

  a_load_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_last_i) |=> in_ready_i)
    else $error("loading stalled inside a set");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (in_ready_i && !out_valid_i))
    else $error("block not back to loading after the final result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_value_i)))
    else $error("stalled result changed");

endmodule

bind lsd_radix_sorter lsdrs_checker u_lsdrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last_out),
  .out_value_i (out_o.sorted_value)
);

@@ test/tb_lsd_radix_sorter.sv @@
`timescale 1ns / 1ps

module tb_lsd_radix_sorter
  import lsdrs_pkg::*;
;

  localparam int unsigned MAX_ITEMS  = 64;
  localparam int unsigned DIGIT_BASE = 10;
  localparam int          N_DIR      = 21;
  localparam int          N_RANDOM   = 150;
  localparam int          HOLD_CYC   = 400;
  localparam int          STALL_LIM  = 40000;

  typedef struct packed {
    val_t value;
    logic last;
  } sorted_item_t;

  typedef struct {
    val_t value;
    logic last;
    logic typed;
    val_t exp_value;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lsdrs_in_if  in_if ();
  lsdrs_out_if out_if ();

  lsd_radix_sorter #(
    .MAX_ITEMS  (MAX_ITEMS),
    .DIGIT_BASE (DIGIT_BASE)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // values of the set being loaded and the sorted runs still to come out
  val_t         set_vals [$];
  val_t         set_max;
  sorted_item_t sorted_exp_q [$];

  int   n_err;
  int   n_sent;
  int   idle_cycles;
  logic burst;
  logic hold_pending;

  // expected item for single-item sets is typed in, all others come from the predictor
  stim_row_t dir_tab [N_DIR] = '{
    '{31'd0,          1'b1, 1'b1, 31'd0},
    '{31'h7FFF_FFFF,  1'b1, 1'b1, 31'h7FFF_FFFF},
    '{31'd7,          1'b1, 1'b1, 31'd7},
    // a set with two equal values
    '{31'd5,          1'b0, 1'b0, 31'd0},
    '{31'd3,          1'b0, 1'b0, 31'd0},
    '{31'd5,          1'b0, 1'b0, 31'd0},
    '{31'd1,          1'b1, 1'b0, 31'd0},
    // ten digit passes
    '{31'd1000000000, 1'b0, 1'b0, 31'd0},
    '{31'd999999999,  1'b0, 1'b0, 31'd0},
    '{31'h7FFF_FFFF,  1'b0, 1'b0, 31'd0},
    '{31'd10,         1'b0, 1'b0, 31'd0},
    '{31'd9,          1'b0, 1'b0, 31'd0},
    '{31'd0,          1'b1, 1'b0, 31'd0},
    '{31'd42,         1'b0, 1'b0, 31'd0},
    '{31'd42,         1'b0, 1'b0, 31'd0},
    '{31'd42,         1'b1, 1'b0, 31'd0},
    '{31'h5555_5555,  1'b0, 1'b0, 31'd0},
    '{31'h2AAA_AAAA,  1'b1, 1'b0, 31'd0},
    '{31'd100,        1'b0, 1'b0, 31'd0},
    '{31'd20,         1'b0, 1'b0, 31'd0},
    '{31'd3,          1'b1, 1'b0, 31'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_sort(input val_t v, input logic l,
                                       ref sorted_item_t res [$]);
    int              cnt     [DIGIT_BASE];
    int              start   [DIGIT_BASE];
    val_t            scratch [MAX_ITEMS];
    int              passes;
    int              d;
    int              acc;
    int              n;
    val_t            rest;
    longint unsigned div;
    if (set_vals.size() < MAX_ITEMS) begin
      set_vals.push_back(v);
      if (v > set_max) set_max = v;
    end
    if (!l) return;
    n = set_vals.size();
    passes = 1;
    rest = set_max;
    while (rest >= DIGIT_BASE) begin
      rest = rest / DIGIT_BASE;
      passes++;
    end
    div = 1;
    repeat (passes) begin
      foreach (cnt[k]) cnt[k] = 0;
      for (int i = 0; i < n; i++) begin
        d = int'((64'(set_vals[i]) / div) % DIGIT_BASE);
        cnt[d]++;
      end
      acc = 0;
      foreach (cnt[k]) begin
        start[k] = acc;
        acc += cnt[k];
      end
      for (int i = 0; i < n; i++) begin
        d = int'((64'(set_vals[i]) / div) % DIGIT_BASE);
        scratch[start[d]] = set_vals[i];
        start[d]++;
      end
      for (int i = 0; i < n; i++) set_vals[i] = scratch[i];
      div = div * DIGIT_BASE;
    end
    for (int i = 0; i < n; i++) res.push_back('{set_vals[i], (i == n - 1)});
    set_vals.delete();
    set_max = '0;
  endfunction

  task automatic send_item(input val_t v, input logic l, input logic typed,
                           input val_t exp_v);
    int           gap;
    sorted_item_t res [$];
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_sort(v, l, res);
    if (typed) begin
      if (l) sorted_exp_q.push_back('{exp_v, 1'b1});
    end else begin
      foreach (res[i]) sorted_exp_q.push_back(res[i]);
    end
    @(negedge clk);
  endtask

  function automatic val_t rand_value(input int kind, input val_t pool [3]);
    case (kind)
      0: rand_value = val_t'($urandom_range(0, 99));
      1: rand_value = val_t'($urandom_range(0, 99999));
      2: rand_value = val_t'($urandom());
      default: rand_value = pool[$urandom_range(0, 2)];
    endcase
  endfunction

  task automatic send_set(input int size, input int kind);
    val_t pool [3];
    foreach (pool[k]) pool[k] = val_t'($urandom());
    pool[0] = val_t'($urandom_range(0, 9));
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < size; i++) begin
      send_item(rand_value(kind, pool), (i == size - 1), 1'b0, '0);
    end
    n_sent += size;
  endtask

  // receiver side
  initial begin
    int           gap;
    sorted_item_t exp_item;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        gap = HOLD_CYC;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (sorted_exp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value=%0d last=%0b",
                 $time, out_if.sorted_value, out_if.last_out);
        n_err++;
      end else begin
        exp_item = sorted_exp_q.pop_front();
        if (out_if.sorted_value !== exp_item.value) begin
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                   $time, exp_item.value, out_if.sorted_value);
          n_err++;
        end
        if (out_if.last_out !== exp_item.last) begin
          $display("%0t: last_out mismatch: expected %0b, actual %0b",
                   $time, exp_item.last, out_if.last_out);
          n_err++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIM) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int size;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.last   = 1'b0;
    rst_n        = 1'b0;
    n_err        = 0;
    n_sent       = 0;
    idle_cycles  = 0;
    burst        = 1'b0;
    hold_pending = 1'b0;
    set_max      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[r]) begin
      send_item(dir_tab[r].value, dir_tab[r].last, dir_tab[r].typed, dir_tab[r].exp_value);
    end

    // full store: the last two values of the first set are dropped, last still sorts
    send_set(MAX_ITEMS + 2, 2);
    send_set(MAX_ITEMS, 1);
    hold_pending = 1'b1;
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_ITEMS)
                                         : $urandom_range(1, 12);
      send_set(size, $urandom_range(0, 3));
    end
    in_if.valid <= 1'b0;

    while (sorted_exp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lsdrs_pkg.sv
hw/rtl/lsdrs_if.sv
hw/rtl/lsdrs_div.sv
hw/rtl/lsdrs_mem.sv
hw/rtl/lsd_radix_sorter.sv
hw/rtl/lsdrs_checker.sv
test/tb_lsd_radix_sorter.sv
